// ===== hdl/status_led_breath_animator_assert.svh =====
// Assertion macros for the status LED breath animator.
`ifndef STATUS_LED_BREATH_ANIMATOR_ASSERT_SVH
`define STATUS_LED_BREATH_ANIMATOR_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define SLBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("status_led_breath_animator: check failed");

// Next-cycle implication, checked out of reset.
`define SLBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("status_led_breath_animator: check failed");

`else

`define SLBA_ASSERT_NOW(label, ante, cons)
`define SLBA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/sled_pkg.sv =====
`default_nettype none

package sled_pkg;

  // Timer widths
  localparam int TIMER_WIDTH = 16;
  localparam int PERIOD_W    = 10;
  localparam int DURATION_W  = 14;
  localparam int CMP_W       = (TIMER_WIDTH > DURATION_W) ? TIMER_WIDTH : DURATION_W;
  localparam int LEVEL_W     = 5;

  // Input function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_MODE  = 2'd1;
  localparam logic [1:0] FUNC_FLASH = 2'd2;

  // Mode codes
  localparam logic [2:0] MODE_OFF        = 3'd0;
  localparam logic [2:0] MODE_CONNECTING = 3'd1;
  localparam logic [2:0] MODE_SEARCHING  = 3'd2;
  localparam logic [2:0] MODE_ACTIVE     = 3'd3;
  localparam logic [2:0] MODE_ERROR      = 3'd4;
  localparam logic [2:0] MODE_CLAIM      = 3'd5;

  // Config register indexes
  localparam logic [1:0] CFG_LED_ENABLE     = 2'd0;
  localparam logic [1:0] CFG_BRIGHT_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_REFRESH_PERIOD = 2'd2;
  localparam logic [1:0] CFG_FLASH_DURATION = 2'd3;
  localparam int         CFG_DATA_W         = DURATION_W;

  // Register reset values
  localparam logic [7:0]            BRIGHT_LIMIT_RST   = 8'd25;
  localparam logic [PERIOD_W-1:0]   REFRESH_PERIOD_RST = PERIOD_W'(30);
  localparam logic [DURATION_W-1:0] FLASH_DURATION_RST = DURATION_W'(600);

  // Breath limits
  localparam logic [LEVEL_W-1:0] BLUE_BOTTOM  = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] BLUE_TOP     = LEVEL_W'(20);
  localparam logic [LEVEL_W-1:0] GREEN_BOTTOM = LEVEL_W'(3);
  localparam logic [LEVEL_W-1:0] GREEN_TOP    = LEVEL_W'(22);

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] mode;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/status_led_breath_animator.sv =====
// Status LED breath animator.
// Input channel (in_valid / in_stall / in_data): each word is a 1 ms tick, a
// mode change or a flash request. A word is taken when in_valid is high and
// in_stall is low. Output channel (out_valid / out_stall / out_data) carries
// the red/green/blue levels each time the LED is written; a word is taken when
// out_valid is high and out_stall is low. Config channel (cfg_valid /
// cfg_ready / cfg_index / cfg_data) writes led_enable, the brightness limit,
// refresh_period_ms and flash_duration_ms; cfg_ready is always high.
// Throughput: one input word per cycle while in_stall is low. All state
// updates for a word happen in the cycle it is taken; its LED word (if any)
// goes to the output register, or to the skid register if the output is
// stalled. A one-word skid register behind the output register lets input
// be taken while a result waits; in_stall rises only once that register fills.
// Reset (rst, synchronous, active high) restores the register defaults
// (enabled, brightness 25, period 30 ms, flash 600 ms), mode off, breath level
// 0 rising, timers cleared, no flash pending and empty output buffers.
`default_nettype none

`include "status_led_breath_animator_assert.svh"

module status_led_breath_animator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire sled_pkg::in_word_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output sled_pkg::out_word_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [sled_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sled_pkg::*;

  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  // Config registers
  logic                  led_enable;
  logic [7:0]            bright_limit;
  logic [PERIOD_W-1:0]   refresh_period_ms;
  logic [DURATION_W-1:0] flash_duration_ms;

  // Animation state
  logic [2:0]             current_mode;
  logic [LEVEL_W-1:0]     breath_level;
  logic                   breath_rising;
  logic [TIMER_WIDTH-1:0] ms_since_refresh;
  logic                   flash_pending;
  logic [TIMER_WIDTH-1:0] flash_age_ms;

  logic [2:0]             current_mode_next;
  logic [LEVEL_W-1:0]     breath_level_next;
  logic                   breath_rising_next;
  logic [TIMER_WIDTH-1:0] ms_since_refresh_next;
  logic                   flash_pending_next;
  logic [TIMER_WIDTH-1:0] flash_age_ms_next;

  // Output buffering
  logic      skid_valid;
  out_word_t skid_data;

  logic      in_accept;
  logic      res_valid;
  logic      produce;
  logic      ref_pass;
  logic      attempt;
  logic      flash_live;
  logic [7:0] raw_r, raw_g, raw_b;
  out_word_t res_word;
  logic [LEVEL_W-1:0] lvl_base;
  logic               rising_base;
  logic [LEVEL_W-1:0] step_level;
  logic               step_rising;
  logic [LEVEL_W-1:0] bottom, top;
  logic [LEVEL_W-1:0] lvl_inc;

  // Cap one channel at the brightness limit, zero when disabled.
  function automatic logic [7:0] cap(input logic [7:0] v, input logic [7:0] m,
                                     input logic en);
    logic [7:0] c;
    c = (v > m) ? m : v;
    return en ? c : 8'd0;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign produce   = in_accept && res_valid;

  // Breath step for the effective mode
  assign bottom  = (current_mode_next == MODE_ACTIVE) ? GREEN_BOTTOM : BLUE_BOTTOM;
  assign top     = (current_mode_next == MODE_ACTIVE) ? GREEN_TOP : BLUE_TOP;
  assign lvl_inc = lvl_base + LEVEL_W'(1);

  always_comb begin
    if (rising_base) begin
      step_level  = lvl_inc;
      step_rising = !(lvl_inc >= top);
    end else if (lvl_base > bottom) begin
      step_level  = lvl_base - LEVEL_W'(1);
      step_rising = 1'b0;
    end else begin
      step_level  = lvl_base;
      step_rising = 1'b1;
    end
  end

  // Per-word update
  always_comb begin
    current_mode_next     = current_mode;
    breath_level_next     = breath_level;
    breath_rising_next    = breath_rising;
    ms_since_refresh_next = ms_since_refresh;
    flash_pending_next    = flash_pending;
    flash_age_ms_next     = flash_age_ms;
    lvl_base              = breath_level;
    rising_base           = breath_rising;
    attempt               = 1'b0;
    res_valid             = 1'b0;
    raw_r                 = 8'd0;
    raw_g                 = 8'd0;
    raw_b                 = 8'd0;

    unique case (in_data.func)
      FUNC_TICK: begin
        attempt = 1'b1;
        if (ms_since_refresh != TIMER_MAX) begin
          ms_since_refresh_next = ms_since_refresh + TIMER_WIDTH'(1);
        end
        if (flash_pending && flash_age_ms != TIMER_MAX) begin
          flash_age_ms_next = flash_age_ms + TIMER_WIDTH'(1);
        end
      end
      FUNC_MODE: begin
        if (in_data.mode <= MODE_CLAIM && in_data.mode != current_mode) begin
          attempt            = 1'b1;
          current_mode_next  = in_data.mode;
          breath_level_next  = '0;
          breath_rising_next = 1'b1;
          lvl_base           = '0;
          rising_base        = 1'b1;
        end
      end
      FUNC_FLASH: begin
        flash_pending_next = 1'b1;
        flash_age_ms_next  = '0;
        res_valid          = 1'b1;
        raw_r              = bright_limit;
        raw_b              = bright_limit;
      end
      default: begin
      end
    endcase

    // Refresh attempt
    ref_pass   = attempt &&
                 (CMP_W'(ms_since_refresh_next) >= CMP_W'(refresh_period_ms));
    flash_live = flash_pending_next &&
                 (CMP_W'(flash_age_ms_next) < CMP_W'(flash_duration_ms));
    if (ref_pass) begin
      ms_since_refresh_next = '0;
      res_valid             = 1'b1;
      if (flash_live) begin
        raw_r = bright_limit;
        raw_b = bright_limit;
      end else begin
        flash_pending_next = 1'b0;
        if (led_enable) begin
          unique case (current_mode_next)
            MODE_CONNECTING: begin
              breath_level_next  = step_level;
              breath_rising_next = step_rising;
              raw_b              = 8'(step_level);
            end
            MODE_SEARCHING: begin
              raw_r = bright_limit;
              raw_g = bright_limit >> 1;
            end
            MODE_ACTIVE: begin
              breath_level_next  = step_level;
              breath_rising_next = step_rising;
              raw_g              = 8'(step_level);
            end
            MODE_ERROR: begin
              raw_r = bright_limit;
            end
            MODE_CLAIM: begin
              raw_r = bright_limit;
              raw_b = bright_limit;
            end
            default: begin
            end
          endcase
        end
      end
    end

    res_word.red   = cap(raw_r, bright_limit, led_enable);
    res_word.green = cap(raw_g, bright_limit, led_enable);
    res_word.blue  = cap(raw_b, bright_limit, led_enable);
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      led_enable        <= 1'b1;
      bright_limit      <= BRIGHT_LIMIT_RST;
      refresh_period_ms <= REFRESH_PERIOD_RST;
      flash_duration_ms <= FLASH_DURATION_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LED_ENABLE:     led_enable        <= cfg_data[0];
        CFG_BRIGHT_LIMIT:   bright_limit      <= cfg_data[7:0];
        CFG_REFRESH_PERIOD: refresh_period_ms <= cfg_data[PERIOD_W-1:0];
        CFG_FLASH_DURATION: flash_duration_ms <= cfg_data[DURATION_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode     <= MODE_OFF;
      breath_level     <= '0;
      breath_rising    <= 1'b1;
      ms_since_refresh <= '0;
      flash_pending    <= 1'b0;
      flash_age_ms     <= '0;
    end else if (in_accept) begin
      current_mode     <= current_mode_next;
      breath_level     <= breath_level_next;
      breath_rising    <= breath_rising_next;
      ms_since_refresh <= ms_since_refresh_next;
      flash_pending    <= flash_pending_next;
      flash_age_ms     <= flash_age_ms_next;
    end
  end

  // Output register and skid register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= produce;
      end else begin
        out_valid  <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  // Output payloads
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= res_word;
      end else begin
        out_data  <= res_word;
      end
    end else if (produce) begin
      skid_data <= res_word;
    end
  end

  // Checks
  `SLBA_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `SLBA_ASSERT_NOW(a_breath_in_range, 1'b1, breath_level <= GREEN_TOP)
  `SLBA_ASSERT_NEXT(a_refresh_clears_timer, in_accept && ref_pass, ms_since_refresh == '0)

endmodule

`default_nettype wire
